@@ rtl/bsed_pkg.sv @@
// ----------------------------------------------------------------------------
// bsed_pkg
// Shared types, widths and constants of the scan-line edge detector.
// ----------------------------------------------------------------------------
`default_nettype none

package bsed_pkg;

    localparam int FRACTION_BITS_DEF = 5;
    localparam int POSITION_BITS_DEF = 16;

    localparam int SAMPLE_W = 8;
    localparam int THR_W    = 8;
    localparam int SLOPE_W  = 9;
    localparam int DIFF2_W  = 11;

    localparam logic [THR_W-1:0] MIN_THR_RESET = 8'd8;
    localparam logic [THR_W-1:0] THR_RESET     = 8'd8;

    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    typedef logic signed [SLOPE_W-1:0] slope_t;
    typedef logic signed [DIFF2_W-1:0] diff2_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_TGO,
        B_TDIV,
        B_CMP,
        B_RES,
        B_IGO,
        B_IDIV
    } back_state_t;

endpackage

`default_nettype wire

@@ rtl/bsed_div.sv @@
// ----------------------------------------------------------------------------
// bsed_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bsed_div
    import bsed_pkg::*;
#(
    parameter int DVD_W = 29,
    parameter int DVS_W = 21
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic      [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W:0]   rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;
    logic             fits;

    always_comb
    begin
        shifted   = {rem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
        fits      = shifted >= {1'b0, dvs_reg};
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            dvd_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (shifted - {1'b0, dvs_reg}) : shifted;
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

`default_nettype wire

@@ rtl/bsed_queue.sv @@
// ----------------------------------------------------------------------------
// bsed_queue
// Two-entry queue of candidate edges between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bsed_queue
    import bsed_pkg::*;
#(
    parameter int DATA_W = 47
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] push_data,
    input  wire logic              pop,
    output logic      [DATA_W-1:0] head,
    output logic                   full,
    output logic                   empty
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg, count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;

endmodule

`default_nettype wire

@@ rtl/bsed_front.sv @@
// ----------------------------------------------------------------------------
// bsed_front
// Smooths samples, forms slopes and second differences, and queues crossings.
// ----------------------------------------------------------------------------
`default_nettype none

module bsed_front
    import bsed_pkg::*;
#(
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [SAMPLE_W-1:0]      sample,
    input  wire logic                     q_full,
    output logic                          push,
    output logic      [POSITION_BITS-1:0] push_pos,
    output slope_t                        push_s1,
    output diff2_t                        push_d1,
    output diff2_t                        push_d2
);

    logic                     started_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [SAMPLE_W-1:0]      h1_reg, h2_reg, h3_reg;
    logic                     accept;
    logic signed [9:0]        delta, delta_adj, delta_half, avg_sum;
    logic [SAMPLE_W-1:0]      a0, a1, a2, a3;
    diff2_t                   e0, e1, e2, e3, s1w, s2w, s1_abs, s2_abs, d1, d2;
    logic                     crossing;

    always_comb
    begin
        a1         = h1_reg;
        a2         = started_reg ? h2_reg : sample;
        a3         = started_reg ? h3_reg : sample;
        delta      = $signed({2'b00, sample}) - $signed({2'b00, h1_reg}) + 10'sd1;
        // Rounding toward zero for a negative odd difference.
        delta_adj  = delta + $signed({9'b0, delta[9]});
        delta_half = delta_adj >>> 1;
        avg_sum    = $signed({2'b00, h1_reg}) + delta_half;
        a0         = started_reg ? avg_sum[SAMPLE_W-1:0] : sample;
        e0         = $signed({3'b000, a0});
        e1         = $signed({3'b000, a1});
        e2         = $signed({3'b000, a2});
        e3         = $signed({3'b000, a3});
        s1w        = e0 - e2;
        s2w        = e1 - e3;
        s1_abs     = s1w[DIFF2_W-1] ? -s1w : s1w;
        s2_abs     = s2w[DIFF2_W-1] ? -s2w : s2w;
        d1         = e0 - (e1 <<< 1) + e2;
        d2         = e1 - (e2 <<< 1) + e3;
        crossing   = (d1 == '0) || ((d1 > 0) ? (d2 < 0) : (d2 > 0));
    end

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign push     = accept && crossing;
    assign push_pos = pos_reg;
    assign push_s1  = (s1_abs < s2_abs) ? s2w[SLOPE_W-1:0] : s1w[SLOPE_W-1:0];
    assign push_d1  = d1;
    assign push_d2  = d2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            pos_reg     <= '0;
            h1_reg      <= '0;
            h2_reg      <= '0;
            h3_reg      <= '0;
        end
        else if (accept)
        begin
            started_reg <= 1'b1;
            pos_reg     <= pos_reg + 1'b1;
            h1_reg      <= a0;
            h2_reg      <= started_reg ? h1_reg : sample;
            h3_reg      <= started_reg ? h2_reg : sample;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bsed_back.sv @@
// ----------------------------------------------------------------------------
// bsed_back
// Applies the adaptive threshold, reports finished elements and interpolates.
// ----------------------------------------------------------------------------
`default_nettype none

module bsed_back
    import bsed_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    parameter int EDGE_W        = POSITION_BITS + FRACTION_BITS,
    parameter int DVD_W         = THR_W + EDGE_W,
    parameter int DVS_W         = (EDGE_W > 12) ? EDGE_W : 12
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [THR_W-1:0]         min_thr,
    input  wire logic                     q_empty,
    input  wire logic [POSITION_BITS-1:0] q_pos,
    input  wire slope_t                   q_s1,
    input  wire diff2_t                   q_d1,
    input  wire diff2_t                   q_d2,
    output logic                          q_pop,
    output logic                          div_start,
    output logic      [DVD_W-1:0]         div_dividend,
    output logic      [DVS_W-1:0]         div_divisor,
    input  wire logic                     div_done,
    input  wire logic [DVD_W-1:0]         div_quot,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic      [EDGE_W-1:0]        edge_width,
    output logic                          is_bar
);

    localparam int NUM_W = DIFF2_W + FRACTION_BITS + 1;

    back_state_t              state_reg, state_next;
    logic [POSITION_BITS-1:0] pos_reg;
    slope_t                   s1_reg;
    diff2_t                   d1_reg, d2_reg;
    logic [THR_W-1:0]         thr_reg, thr_next;
    logic [THR_W-1:0]         eff_reg, eff_next;
    logic [EDGE_W-1:0]        track_reg, track_next;
    logic [EDGE_W-1:0]        pedge_reg, pedge_next;
    logic [EDGE_W-1:0]        pwidth_reg, pwidth_next;
    logic [1:0]               sign_reg, sign_next;
    logic [DVD_W-1:0]         prod_reg, prod_next;
    logic                     res_reg, res_next;
    logic                     ov_reg, ov_next;
    logic [EDGE_W-1:0]        ow_reg, ow_next;
    logic                     ob_reg, ob_next;

    logic [EDGE_W-1:0]        pos_fix, span, pw_new, edge_off, quot_s;
    logic [DVD_W-1:0]         t_round, thr_ext;
    logic [THR_W-1:0]         s1_abs, half;
    logic signed [9:0]        hv, hv_adj, hh;
    logic                     reversal, pass, skip_thr, thr_sat, out_free, direct;
    logic signed [DIFF2_W:0]  diff;
    logic [DIFF2_W:0]         diff_abs;
    logic signed [NUM_W-1:0]  num;
    logic [NUM_W-1:0]         num_abs;
    logic                     neg;

    always_comb
    begin
        pos_fix  = {pos_reg, {FRACTION_BITS{1'b0}}};
        span     = pos_fix - pedge_reg;
        t_round  = ((div_quot >> (FRACTION_BITS + 1)) + 1'b1) >> 1;
        thr_ext  = DVD_W'(thr_reg);
        thr_sat  = (t_round >= thr_ext) || ((thr_ext - t_round) < DVD_W'(min_thr));
        skip_thr = (thr_reg <= min_thr) || (pwidth_reg == '0);
        s1_abs   = s1_reg[SLOPE_W-1] ? THR_W'(-s1_reg) : s1_reg[THR_W-1:0];
        pass     = eff_reg < s1_abs;
        reversal = (sign_reg == SIGN_POS) ? (s1_reg < 0) : (s1_reg > 0);
        pw_new   = track_reg - pedge_reg;
        hv       = 10'(s1_reg) + 10'sd1;
        hv_adj   = hv + $signed({9'b0, hv[9]});
        hh       = hv_adj >>> 1;
        half     = hh[9] ? THR_W'(-hh) : hh[THR_W-1:0];
        diff     = (DIFF2_W + 1)'(d1_reg) - (DIFF2_W + 1)'(d2_reg);
        diff_abs = diff[DIFF2_W] ? (DIFF2_W + 1)'(-diff) : diff;
        num      = (NUM_W'(d1_reg) <<< FRACTION_BITS) + NUM_W'(1);
        num_abs  = num[NUM_W-1] ? NUM_W'(-num) : num;
        neg      = num[NUM_W-1] ^ diff[DIFF2_W];
        direct   = (diff == '0) || (d1_reg == '0);
        quot_s   = neg ? EDGE_W'(-div_quot[EDGE_W-1:0]) : div_quot[EDGE_W-1:0];
        edge_off = (diff == '0) ? EDGE_W'(1 << (FRACTION_BITS - 1))
                                : EDGE_W'(1 << FRACTION_BITS);
        out_free = !ov_reg || !out_stall;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: state_next = q_empty ? B_IDLE : B_MUL;
            B_MUL:  state_next = skip_thr ? B_CMP : B_TGO;
            B_TGO:  state_next = B_TDIV;
            B_TDIV: state_next = div_done ? B_CMP : B_TDIV;
            B_CMP:  state_next = pass ? B_RES : B_IDLE;
            B_RES:
            begin
                if (!res_reg || out_free)
                begin
                    state_next = direct ? B_IDLE : B_IGO;
                end
            end
            B_IGO:  state_next = B_IDIV;
            B_IDIV: state_next = div_done ? B_IDLE : B_IDIV;
            default: state_next = B_IDLE;
        endcase
    end

    // Outputs and datapath updates.
    always_comb
    begin
        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = DVD_W'(num_abs);
        div_divisor  = DVS_W'(diff_abs);
        thr_next     = thr_reg;
        eff_next     = eff_reg;
        track_next   = track_reg;
        pedge_next   = pedge_reg;
        pwidth_next  = pwidth_reg;
        sign_next    = sign_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        ov_next      = ov_reg && out_stall;
        ow_next      = ow_reg;
        ob_next      = ob_reg;
        case (state_reg)
            B_IDLE:
            begin
                q_pop = !q_empty;
            end
            B_MUL:
            begin
                eff_next  = min_thr;
                prod_next = DVD_W'(thr_reg) * DVD_W'(span);
            end
            B_TGO:
            begin
                div_start    = 1'b1;
                div_dividend = prod_reg;
                div_divisor  = DVS_W'(pwidth_reg);
            end
            B_TDIV:
            begin
                div_dividend = prod_reg;
                div_divisor  = DVS_W'(pwidth_reg);
                if (div_done)
                begin
                    if (thr_sat)
                    begin
                        thr_next = min_thr;
                        eff_next = min_thr;
                    end
                    else
                    begin
                        eff_next = thr_reg - t_round[THR_W-1:0];
                    end
                end
            end
            B_CMP:
            begin
                res_next = 1'b0;
                if (pass && reversal)
                begin
                    pwidth_next = pw_new;
                    pedge_next  = track_reg;
                    thr_next    = (half < min_thr) ? min_thr : half;
                    if (pw_new != '0)
                    begin
                        sign_next = (s1_reg > 0) ? SIGN_POS : SIGN_NEG;
                        res_next  = 1'b1;
                    end
                end
            end
            B_RES:
            begin
                if (!res_reg || out_free)
                begin
                    if (res_reg)
                    begin
                        ov_next  = 1'b1;
                        ow_next  = pwidth_reg;
                        ob_next  = s1_reg > 0;
                        res_next = 1'b0;
                    end
                    if (direct)
                    begin
                        track_next = edge_off + pos_fix;
                    end
                end
            end
            B_IGO:
            begin
                div_start = 1'b1;
            end
            B_IDIV:
            begin
                if (div_done)
                begin
                    track_next = EDGE_W'(1 << FRACTION_BITS) - quot_s + pos_fix;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            thr_reg    <= THR_RESET;
            track_reg  <= '0;
            pedge_reg  <= '0;
            pwidth_reg <= '0;
            sign_reg   <= SIGN_ZERO;
            res_reg    <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            thr_reg    <= thr_next;
            track_reg  <= track_next;
            pedge_reg  <= pedge_next;
            pwidth_reg <= pwidth_next;
            sign_reg   <= sign_next;
            res_reg    <= res_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eff_reg  <= eff_next;
        prod_reg <= prod_next;
        ow_reg   <= ow_next;
        ob_reg   <= ob_next;
        if (q_pop)
        begin
            pos_reg <= q_pos;
            s1_reg  <= q_s1;
            d1_reg  <= q_d1;
            d2_reg  <= q_d2;
        end
    end

    assign out_valid  = ov_reg;
    assign edge_width = ow_reg;
    assign is_bar     = ob_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && !q_empty) |=> (state_reg == B_MUL))
        else $error("queued candidate was not taken up");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == B_TDIV || state_reg == B_IDIV))
        else $error("divider finished outside a wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (sign_reg == SIGN_POS || sign_reg == SIGN_NEG || sign_reg == SIGN_ZERO))
        else $error("slope sign holds an invalid code");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(edge_width)))
        else $error("stalled result was overwritten");
`endif

endmodule

`default_nettype wire

@@ rtl/barcode_scanline_edge_detector.sv @@
// A sample without a second-difference crossing is absorbed by the front end alone.
// A crossing is queued; the back end pops it and steps through MUL, CMP and, if it
// passes, RES, with serial divisions for threshold decay and interpolation as needed.
// Throughput: one sample per cycle until the two-entry queue fills; then the
// back end's shared one-bit-per-cycle divider sets the rate.
// Reset: asynchronous, active low; clears all control and edge tracking state.
`default_nettype none

module barcode_scanline_edge_detector
    import bsed_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [SAMPLE_W-1:0]                    sample,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic      [POSITION_BITS+FRACTION_BITS-1:0] edge_width,
    output logic                                        is_bar,
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [THR_W-1:0]                       cfg_data
);

    localparam int EDGE_W = POSITION_BITS + FRACTION_BITS;
    localparam int DVD_W  = THR_W + EDGE_W;
    localparam int DVS_W  = (EDGE_W > 12) ? EDGE_W : 12;
    localparam int Q_W    = POSITION_BITS + SLOPE_W + 2 * DIFF2_W;

    logic [THR_W-1:0]         min_thr_reg;
    logic                     push, q_full, q_empty, q_pop;
    logic [POSITION_BITS-1:0] push_pos, q_pos;
    slope_t                   push_s1, q_s1;
    diff2_t                   push_d1, push_d2, q_d1, q_d2;
    logic [Q_W-1:0]           q_head;
    logic                     div_start, div_done;
    logic [DVD_W-1:0]         div_dividend, div_quot;
    logic [DVS_W-1:0]         div_divisor;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_thr_reg <= MIN_THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            min_thr_reg <= cfg_data;
        end
    end

    bsed_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sample   (sample),
        .q_full   (q_full),
        .push     (push),
        .push_pos (push_pos),
        .push_s1  (push_s1),
        .push_d1  (push_d1),
        .push_d2  (push_d2)
    );

    bsed_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_pos, push_s1, push_d1, push_d2}),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign {q_pos, q_s1, q_d1, q_d2} = q_head;

    bsed_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    bsed_back #(
        .FRACTION_BITS (FRACTION_BITS),
        .POSITION_BITS (POSITION_BITS),
        .EDGE_W        (EDGE_W),
        .DVD_W         (DVD_W),
        .DVS_W         (DVS_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .min_thr      (min_thr_reg),
        .q_empty      (q_empty),
        .q_pos        (q_pos),
        .q_s1         (q_s1),
        .q_d1         (q_d1),
        .q_d2         (q_d2),
        .q_pop        (q_pop),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_done     (div_done),
        .div_quot     (div_quot),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .edge_width   (edge_width),
        .is_bar       (is_bar)
    );

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// Scan-line edge detector testbench
// Feeds intensity samples through the valid/stall input channel, predicts
// every element width and color with a local model of the smoothing, edge
// interpolation and adaptive threshold, and checks each result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import bsed_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = FRACTION_BITS_DEF;
    localparam int PB = POSITION_BITS_DEF;
    localparam int EW = PB + FB;
    localparam int LATENCY = 400;

    typedef struct packed {
        logic [EW-1:0] width;
        logic          bar;
    } element_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [SAMPLE_W-1:0] sample;
    logic out_valid;
    logic out_stall;
    logic [EW-1:0] edge_width;
    logic is_bar;
    logic cfg_valid;
    logic cfg_ready;
    logic [THR_W-1:0] cfg_data;

    barcode_scanline_edge_detector dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
        .out_valid(out_valid), .out_stall(out_stall),
        .edge_width(edge_width), .is_bar(is_bar),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // Local copy of the detector state.
    logic [7:0]    m_min_thr;
    logic          m_started;
    logic [PB-1:0] m_pos;
    int            m_ring [4];
    int            m_sign;
    logic [7:0]    m_thr;
    logic [EW-1:0] m_track;
    logic [EW-1:0] m_prev_edge;
    logic [EW-1:0] m_prev_width;

    element_t expected_elements [$];
    int errors = 0;
    int results_seen = 0;
    int samples_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    function automatic int magnitude(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int unsigned current_threshold();
        longint unsigned span, t;
        if (m_thr <= m_min_thr || m_prev_width == 0)
            return m_min_thr;
        span = (({m_pos, {FB{1'b0}}}) - m_prev_edge) & ((64'd1 << EW) - 1);
        t = longint'(m_thr) * span;
        t = t / m_prev_width;
        t = t / 4;
        t = ((t >> (FB - 1)) + 1) >> 1;
        if (t >= m_thr || m_thr - t < m_min_thr)
        begin
            m_thr = m_min_thr;
            return m_min_thr;
        end
        return m_thr - int'(t);
    endfunction

    task automatic predict_sample(input logic [7:0] y);
        int a0, a1, a2, a3, s1, s2, d1, d2, diff;
        int unsigned half;
        longint edge_pos;
        logic crossing;
        logic reversal;
        a1 = m_ring[(m_pos - 1) & 3];
        if (m_started)
        begin
            a0 = a1 + (int'(y) - a1 + 1) / 2;
            m_ring[m_pos & 3] = a0;
        end
        else
        begin
            a0 = y;
            for (int i = 0; i < 4; i++)
                m_ring[i] = y;
            m_started = 1'b1;
        end
        a2 = m_ring[(m_pos - 2) & 3];
        a3 = m_ring[(m_pos - 3) & 3];
        s1 = a0 - a2;
        s2 = a1 - a3;
        if (magnitude(s1) < magnitude(s2))
            s1 = s2;
        d1 = a0 - 2 * a1 + a2;
        d2 = a1 - 2 * a2 + a3;
        crossing = (d1 == 0) || (d1 > 0 ? d2 < 0 : d2 > 0);
        if (crossing && current_threshold() < magnitude(s1))
        begin
            reversal = (m_sign > 0) ? (s1 < 0) : (s1 > 0);
            if (reversal)
            begin
                m_prev_width = m_track - m_prev_edge;
                m_prev_edge = m_track;
                half = magnitude((s1 + 1) / 2);
                m_thr = half < m_min_thr ? m_min_thr : half[7:0];
                if (m_prev_width != 0)
                begin
                    m_sign = s1 > 0 ? 1 : -1;
                    expected_elements.push_back('{m_prev_width, s1 > 0});
                end
            end
            diff = d1 - d2;
            edge_pos = longint'(1) << FB;
            if (diff == 0)
                edge_pos = edge_pos >>> 1;
            else if (d1 != 0)
                edge_pos -= (longint'(d1) * (longint'(1) << FB) + 1) / longint'(diff);
            m_track = EW'(edge_pos) + {m_pos, {FB{1'b0}}};
        end
        m_pos = m_pos + 1'b1;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("tb: errors");
        $finish;
    end

    // Receiver: random stall and in-order checking of each result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_elements.size() == 0)
                begin
                    $error("unexpected result: edge_width %0d is_bar %0d", edge_width, is_bar);
                    errors++;
                end
                else
                begin
                    element_t e;
                    e = expected_elements.pop_front();
                    if (edge_width !== e.width)
                    begin
                        $error("edge_width expected %0d actual %0d", e.width, edge_width);
                        errors++;
                    end
                    if (is_bar !== e.bar)
                    begin
                        $error("is_bar expected %0d actual %0d", e.bar, is_bar);
                        errors++;
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // The caller drops in_valid once no further sample follows.
    task automatic send_sample(input logic [7:0] y);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= y;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_sample(y);
        samples_sent++;
    endtask

    task automatic write_min_threshold(input logic [7:0] value);
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (expected_elements.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        m_min_thr = value;
    endtask

    // One scan line: alternating bars and spaces of random widths.
    task automatic send_scanline(input int n);
        logic [7:0] level;
        int run;
        level = $urandom_range(1) ? 8'($urandom_range(200, 255)) : 8'($urandom_range(0, 50));
        while (n > 0)
        begin
            run = $urandom_range(1, 12);
            level = (level > 127) ? 8'($urandom_range(0, 60)) : 8'($urandom_range(190, 255));
            for (int i = 0; i < run && n > 0; i++, n--)
            begin
                if ($urandom_range(9) == 0)
                    send_sample(8'($urandom));
                else
                    send_sample(8'(int'(level) + $urandom_range(0, 6) - 3 < 0 ? 0 :
                        (int'(level) + $urandom_range(0, 6) > 258 ? 255 :
                        int'(level) + $urandom_range(0, 6) - 3)));
            end
        end
    endtask

    // Directed table: extremes and sharp bar/space transitions.
    logic [7:0] directed_table [] = '{
        8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0,
        8'd255, 8'd255, 8'd128, 8'd128, 8'd128, 8'd0, 8'd0, 8'd255, 8'd255,
        8'd1, 8'd254, 8'd254, 8'd0, 8'd0, 8'd0
    };

    int phase_idle [4] = '{0, 58, 0, 17};
    int phase_stall [4] = '{0, 0, 58, 17};
    logic [7:0] thr_settings [4] = '{8'd255, 8'd1, 8'd0, 8'd40};

    initial
    begin
        int guard;
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        m_min_thr = MIN_THR_RESET;
        m_started = 1'b0;
        m_pos = '0;
        for (int i = 0; i < 4; i++)
            m_ring[i] = 0;
        m_sign = 0;
        m_thr = THR_RESET;
        m_track = '0;
        m_prev_edge = '0;
        m_prev_width = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_table[i])
            send_sample(directed_table[i]);

        for (int p = 0; p < 4; p++)
        begin
            write_min_threshold(thr_settings[p]);
            send_idle_pct = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            for (int k = 0; k < 3; k++)
                send_scanline(80 + $urandom_range(0, 80));
            for (int k = 0; k < 40; k++)
                send_sample(8'($urandom));
        end
        write_min_threshold(MIN_THR_RESET);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        send_scanline(320);

        in_valid <= 1'b0;
        guard = 0;
        while (expected_elements.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY) @(posedge clk);
        if (expected_elements.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_elements.size());
            errors++;
        end
        $display("Sent %0d samples over five threshold settings and five handshake mixes;",
            samples_sent);
        $display("checked %0d element widths.", results_seen);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

`default_nettype wire

@@ filelist.f @@
rtl/bsed_pkg.sv
rtl/bsed_div.sv
rtl/bsed_queue.sv
rtl/bsed_front.sv
rtl/bsed_back.sv
rtl/barcode_scanline_edge_detector.sv
test/tb.sv
